@@ hw/rtl/stbs_pkg.sv @@
// Shared types and constants for the sorted table bound search block.
// Used by every module of the block but the RAM; depends on nothing else.
`default_nettype none

package stbs_pkg;

  // Default sizes of the table memory.
  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned WORD_WIDTH_DEF  = 32;

  // Fixed field widths of the stream and register words.
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned COUNT_W = 11;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Register index of the entry count (byte address 4 * index).
  localparam logic REG_IDX_ENTRY_COUNT = 1'b0;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } stbs_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_DONE = 4'b1000
  } stbs_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write;
    logic start;
    logic compare;
    logic publish;
  } stbs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic search_done;
    logic out_free;
  } stbs_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/stbs_ram.sv @@
// Generic RAM with one write/read port and one read port, registered reads.
// Stands alone; no package needed.
`default_nettype none

module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     a_we_i,
  input  wire logic [$clog2(DEPTH)-1:0] a_addr_i,
  input  wire logic [WIDTH-1:0]         a_wdata_i,
  output logic      [WIDTH-1:0]         a_rdata_o,
  input  wire logic [$clog2(DEPTH)-1:0] b_addr_i,
  output logic      [WIDTH-1:0]         b_rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] a_rdata_q;
  logic [WIDTH-1:0] b_rdata_q;

  always_ff @(posedge clk_i) begin
    if (a_we_i) begin
      mem_q[a_addr_i] <= a_wdata_i;
    end
    a_rdata_q <= mem_q[a_addr_i];
    b_rdata_q <= mem_q[b_addr_i];
  end

  assign a_rdata_o = a_rdata_q;
  assign b_rdata_o = b_rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/stbs_ctrl.sv @@
// Sequencer for the bound search: accepts words, steps the probe loop and
// hands finished results to the output register. Uses stbs_pkg.
`default_nettype none

module stbs_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_kind_i,
  output logic                       in_ready_o,
  input  wire stbs_pkg::stbs_status_t status_i,
  output stbs_pkg::stbs_cmd_t        cmd_o
);
  import stbs_pkg::*;

  stbs_state_e state_q, state_d;
  logic        accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.write   = accept && (in_kind_i == KIND_WRITE);
    cmd_o.start   = accept && (in_kind_i == KIND_QUERY);
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.start) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // The probe addresses are at the memory; finish once both ranges are empty.
        if (status_i.search_done) begin
          if (status_i.out_free) begin
            cmd_o.publish = 1'b1;
            state_d       = ST_IDLE;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = ST_READ;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/stbs_dp.sv @@
// Datapath of the bound search: table memory, the two search ranges,
// the comparators and the result register. Uses stbs_pkg and stbs_ram.
`default_nettype none

module stbs_dp #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned WORD_WIDTH  = stbs_pkg::WORD_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire stbs_pkg::stbs_cmd_t           cmd_i,
  output stbs_pkg::stbs_status_t             status_o,
  input  wire logic [stbs_pkg::IDX_W-1:0]    entry_index_i,
  input  wire logic signed [stbs_pkg::VAL_W-1:0] item_value_i,
  input  wire logic [stbs_pkg::COUNT_W-1:0]  entry_count_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               found_o,
  output logic [stbs_pkg::POS_W-1:0]         first_position_o,
  output logic [stbs_pkg::POS_W-1:0]         upper_position_o
);
  import stbs_pkg::*;

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);

  logic signed [WORD_WIDTH-1:0] key_q;
  logic signed [WORD_WIDTH-1:0] in_word;
  logic [POS_W-1:0]             n_q, n_d;
  // Lower bound search keeps an exclusive upper end; upper bound search too.
  logic [POS_W-1:0]             lb_lo_q, lb_hi_q, ub_lo_q, ub_hi_q;
  logic [POS_W-1:0]             hit_q;
  logic                         hit_valid_q;
  logic [POS_W:0]               lb_sum, ub_sum;
  logic [POS_W-1:0]             lb_mid, ub_mid;
  logic                         lb_done, ub_done;
  logic                         wr_in_range;
  logic [ADDR_W-1:0]            a_addr, b_addr;
  logic [WORD_WIDTH-1:0]        a_rdata, b_rdata;
  logic signed [WORD_WIDTH-1:0] lb_entry, ub_entry;
  logic                         out_valid_q;
  logic                         out_found_q;
  logic [POS_W-1:0]             out_first_q, out_upper_q;
  logic                         out_free;

  // Sign-extend or cut the 32-bit value to the stored word width.
  assign in_word = WORD_WIDTH'(item_value_i);

  always_comb begin
    if (int'(entry_count_i) > int'(TABLE_DEPTH)) begin
      n_d = POS_W'(TABLE_DEPTH);
    end else begin
      n_d = entry_count_i;
    end
  end

  // Floored midpoints; the lower bound one uses the inclusive high end hi - 1.
  assign lb_sum  = {1'b0, lb_lo_q} + {1'b0, lb_hi_q} - (POS_W + 1)'(1);
  assign lb_mid  = lb_sum[POS_W:1];
  assign ub_sum  = {1'b0, ub_lo_q} + {1'b0, ub_hi_q};
  assign ub_mid  = ub_sum[POS_W:1];
  assign lb_done = !(lb_lo_q < lb_hi_q);
  assign ub_done = !(ub_lo_q < ub_hi_q);

  assign wr_in_range = int'(entry_index_i) < int'(TABLE_DEPTH);
  assign a_addr      = cmd_i.write ? ADDR_W'(entry_index_i) : ADDR_W'(lb_mid);
  assign b_addr      = ADDR_W'(ub_mid);

  stbs_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .a_we_i    (cmd_i.write && wr_in_range),
    .a_addr_i  (a_addr),
    .a_wdata_i (in_word),
    .a_rdata_o (a_rdata),
    .b_addr_i  (b_addr),
    .b_rdata_o (b_rdata)
  );

  assign lb_entry = a_rdata;
  assign ub_entry = b_rdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q       <= in_word;
      n_q         <= n_d;
      lb_lo_q     <= '0;
      lb_hi_q     <= n_d;
      ub_lo_q     <= '0;
      ub_hi_q     <= n_d;
      hit_q       <= n_d;
      hit_valid_q <= 1'b0;
    end else if (cmd_i.compare) begin
      if (!lb_done) begin
        if (lb_entry >= key_q) begin
          if (lb_entry == key_q) begin
            hit_q       <= lb_mid;
            hit_valid_q <= 1'b1;
          end
          lb_hi_q <= lb_mid;
        end else begin
          lb_lo_q <= lb_mid + POS_W'(1);
        end
      end
      if (!ub_done) begin
        if (ub_entry > key_q) begin
          ub_hi_q <= ub_mid;
        end else begin
          ub_lo_q <= ub_mid + POS_W'(1);
        end
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_found_q <= hit_valid_q;
      out_first_q <= hit_valid_q ? hit_q : ub_lo_q;
      out_upper_q <= ub_lo_q;
    end
  end

  assign status_o.search_done = lb_done && ub_done;
  assign status_o.out_free    = out_free;

  assign out_valid_o      = out_valid_q;
  assign found_o          = out_found_q;
  assign first_position_o = out_first_q;
  assign upper_position_o = out_upper_q;

`ifndef ASSERT_OFF
  // A result may only be loaded when the previous one has left.
  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |-> out_free)
    else $error("result loaded over a waiting result");

  // Both search ranges stay ordered and inside the entries in use.
  a_ranges_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.compare |-> (lb_lo_q <= lb_hi_q) && (lb_hi_q <= n_q)
                      && (ub_lo_q <= ub_hi_q) && (ub_hi_q <= n_q))
    else $error("search range out of order");

  // A recorded hit always points at an entry in use.
  a_hit_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.compare && hit_valid_q) |-> (hit_q < n_q))
    else $error("hit position beyond entry count");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/sorted_table_bound_search_top.sv @@
// Top level of the sorted table bound search: stream ports, APB register
// port, controller and datapath. Uses stbs_pkg, stbs_ctrl and stbs_dp.
//
//   Channel     Direction  Word contents
//   s_axis      in         tuser: kind; tdata: entry_index, item_value
//   m_axis      out        tuser: found; tdata: first_position, upper_position
//   apb         in/out     entry_count register at byte address 0
//
// After a write word the next word can follow in the next cycle.
// A query runs P probes, where P is the larger probe count of the two searches
// (at most ceil(log2(n + 1)), 11 for 1024 entries), and then publishes;
// each probe is a memory read state and a compare state on the table RAM.
// Reset clears the controller, the output valid flag and entry_count; the
// table memory is not cleared and must be written before it is searched.
// A query may start while an earlier result waits; it holds at its end until
// the output register frees up, and no new word is taken during a search.
`default_nettype none

module sorted_table_bound_search_top #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned WORD_WIDTH  = stbs_pkg::WORD_WIDTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Input words.
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [9:0] entry_index, [41:10] item_value, [47:42] zero.
  input  wire logic [stbs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] kind.
  input  wire logic [0:0]                          s_axis_tuser,
  // Result words.
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [10:0] first_position, [21:11] upper_position, [23:22] zero.
  output logic [stbs_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  // [0] found.
  output logic [0:0]                               m_axis_tuser,
  // Register port.
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [stbs_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [stbs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [stbs_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                     pready
);
  import stbs_pkg::*;

  logic [COUNT_W-1:0]      entry_count_q;
  logic                    reg_write;
  logic                    reg_hit;
  stbs_cmd_t               cmd;
  stbs_status_t            status;
  logic                    found;
  logic [POS_W-1:0]        first_position;
  logic [POS_W-1:0]        upper_position;

  // The register port never waits; a write lands on the access cycle.
  assign pready    = 1'b1;
  assign reg_hit   = (paddr[APB_ADDR_W-1:2] == REG_IDX_ENTRY_COUNT);
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (reg_write && reg_hit) begin
      entry_count_q <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = reg_hit ? {{(APB_DATA_W - COUNT_W){1'b0}}, entry_count_q} : '0;

  stbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .entry_index_i    (s_axis_tdata[IDX_W-1:0]),
    .item_value_i     (s_axis_tdata[IDX_W+VAL_W-1:IDX_W]),
    .entry_count_i    (entry_count_q),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .found_o          (found),
    .first_position_o (first_position),
    .upper_position_o (upper_position)
  );

  assign m_axis_tuser = found;
  assign m_axis_tdata = {{(OUT_TDATA_W - 2 * POS_W){1'b0}}, upper_position, first_position};

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for sorted_table_bound_search_top: streams table writes and bound queries,
// predicts each result word in a small scoreboard class and checks it field by field.
// Depends on stbs_pkg and the RTL of the block; needs no files or arguments.

module tb_top;
  import stbs_pkg::*;

  localparam int unsigned DEPTH = TABLE_DEPTH_DEF;

  // Byte addresses of the register port. Index 1 has no register behind it.
  localparam logic [APB_ADDR_W-1:0] ADDR_ENTRY_COUNT = {REG_IDX_ENTRY_COUNT, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED    = 3'd4;

  localparam int VAL_MIN = 32'h8000_0000;
  localparam int VAL_MAX = 32'h7fff_ffff;

  // Leave a margin for a query in flight before touching the register.
  localparam int unsigned DRAIN_CYCLES = 40;
  // Length of the one long output hold-off that backs the block up.
  localparam int unsigned HOLD_CYCLES  = 600;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] upper_pos;
  } bound_result_t;

  // Keeps its own copy of the table and entry count, computes the expected
  // result of every accepted query and compares it with what comes out.
  class bound_scoreboard;
    int            table_word [DEPTH];
    bit            written    [DEPTH];
    int unsigned   entry_count;
    bound_result_t expected_q [$];
    int unsigned   err_count;
    int unsigned   n_writes;
    int unsigned   n_queries;
    int unsigned   n_hits;
    int unsigned   n_checked;

    function new();
      entry_count = 0;
      err_count   = 0;
      n_writes    = 0;
      n_queries   = 0;
      n_hits      = 0;
      n_checked   = 0;
    endfunction

    function int unsigned active_entries();
      return (entry_count > DEPTH) ? DEPTH : entry_count;
    endfunction

    function bit prefix_written(int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
        if (!written[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Lower bound search: the last probe that hit an equal entry wins.
    function int first_equal(int unsigned n, int value);
      int lo;
      int hi;
      int mid;
      int hit;
      lo  = 0;
      hi  = int'(n) - 1;
      hit = int'(n);
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (table_word[mid] >= value) begin
          if (table_word[mid] == value) hit = mid;
          hi = mid - 1;
        end else begin
          lo = mid + 1;
        end
      end
      return hit;
    endfunction

    function int upper_bound(int unsigned n, int value);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = int'(n);
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (table_word[mid] > value) hi = mid;
        else lo = mid + 1;
      end
      return lo;
    endfunction

    function void note_word(stbs_kind_e kind, logic [IDX_W-1:0] idx, int value);
      int unsigned   n;
      int            first;
      int            upper;
      bound_result_t r;
      if (kind == KIND_WRITE) begin
        table_word[idx] = value;
        written[idx]    = 1'b1;
        n_writes++;
        return;
      end
      n           = active_entries();
      first       = first_equal(n, value);
      upper       = upper_bound(n, value);
      r.found     = (first != int'(n));
      r.first_pos = r.found ? POS_W'(first) : POS_W'(upper);
      r.upper_pos = POS_W'(upper);
      expected_q.push_back(r);
      n_queries++;
      if (r.found) n_hits++;
    endfunction

    function void check_result(logic found, logic [POS_W-1:0] first_pos,
                               logic [POS_W-1:0] upper_pos);
      bound_result_t e;
      if (expected_q.size() == 0) begin
        $error("result word with no query pending: found=%0d first=%0d upper=%0d",
               found, first_pos, upper_pos);
        err_count++;
        return;
      end
      e = expected_q.pop_front();
      n_checked++;
      if (found !== e.found) begin
        $error("found: expected %0d, actual %0d", e.found, found);
        err_count++;
      end
      if (first_pos !== e.first_pos) begin
        $error("first_position: expected %0d, actual %0d", e.first_pos, first_pos);
        err_count++;
      end
      if (upper_pos !== e.upper_pos) begin
        $error("upper_position: expected %0d, actual %0d", e.upper_pos, upper_pos);
        err_count++;
      end
    endfunction
  endclass

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  wire                     s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic [0:0]              s_axis_tuser  = '0;
  wire                     m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  wire  [OUT_TDATA_W-1:0]  m_axis_tdata;
  wire  [0:0]              m_axis_tuser;
  logic                    psel          = 1'b0;
  logic                    penable       = 1'b0;
  logic                    pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr         = '0;
  logic [APB_DATA_W-1:0]   pwdata        = '0;
  wire  [APB_DATA_W-1:0]   prdata;
  wire                     pready;

  bound_scoreboard sb = new();

  // Set by the stimulus once; the result sink clears it after the hold-off.
  bit          hold_request = 1'b0;
  // Words left in the current input burst.
  int unsigned burst_left   = 0;
  int unsigned n_settings   = 0;

  sorted_table_bound_search_top DUT (.*);

  always #5 clk_i = ~clk_i;

  // Outputs are sampled in the active region of the edge, so they still hold
  // the values from before the edge, as does our own tready.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tuser[0], m_axis_tdata[POS_W-1:0],
                      m_axis_tdata[2*POS_W-1:POS_W]);
    end
  end

  // Result sink. It switches among several stall patterns and, when asked,
  // holds tready low for a long stretch so that results pile up in the
  // block and its input stalls while the sender keeps offering words.
  initial begin : result_sink
    int unsigned mode;
    int unsigned span;
    int unsigned stall_left;
    stall_left = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      for (int unsigned k = 0; k < span; k++) begin
        if (hold_request) break;
        case (mode)
          0: begin
            m_axis_tready <= 1'b1;
          end
          1: begin
            m_axis_tready <= ($urandom_range(0, 9) < 7);
          end
          2: begin
            m_axis_tready <= (k % 4 == 0);
          end
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
              stall_left = $urandom_range(2, 12);
              m_axis_tready <= 1'b0;
            end else begin
              m_axis_tready <= 1'b1;
            end
          end
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Offers one input word and returns at the edge that accepts it. Words go
  // out in bursts of random length; valid drops for a gap between bursts, so it
  // is never lowered and raised in the same step.
  task automatic send_word(stbs_kind_e kind, logic [IDX_W-1:0] idx, int value);
    int unsigned gap;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(IN_TDATA_W-IDX_W-VAL_W){1'b0}}, value, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(kind, idx, value);
  endtask

  task automatic send_write(int unsigned idx, int value);
    send_word(KIND_WRITE, IDX_W'(idx), value);
  endtask

  // The index field means nothing to a query, so it carries noise.
  task automatic send_query(int value);
    send_word(KIND_QUERY, IDX_W'($urandom), value);
  endtask

  // Waits until every expected result is in, then lets the block settle,
  // since a trailing table write gives no result to wait for.
  task automatic drain();
    int unsigned guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(logic [APB_ADDR_W-1:0] addr, output logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Changes entry_count while the block is idle. The upper bits of the data
  // word sometimes carry noise, and sometimes the unmapped address is written
  // as well; neither may change the count. The count is read back.
  task automatic set_count(int unsigned count);
    logic [APB_DATA_W-1:0] word;
    logic [APB_DATA_W-1:0] rd;
    drain();
    word = APB_DATA_W'(count);
    if ($urandom_range(0, 2) == 0) word = ($urandom << COUNT_W) | word;
    apb_write(ADDR_ENTRY_COUNT, word);
    sb.entry_count = word[COUNT_W-1:0];
    if ($urandom_range(0, 2) == 0) apb_write(ADDR_UNMAPPED, $urandom);
    apb_read(ADDR_ENTRY_COUNT, rd);
    if (rd[COUNT_W-1:0] !== word[COUNT_W-1:0]) begin
      $error("entry_count: expected %0d, actual %0d", word[COUNT_W-1:0], rd[COUNT_W-1:0]);
      sb.err_count++;
    end
    n_settings++;
  endtask

  function automatic int clamp_word(longint v);
    if (v > VAL_MAX) return VAL_MAX;
    if (v < VAL_MIN) return VAL_MIN;
    return int'(v);
  endfunction

  // Writes positions 0 to n-1 with an ascending sequence. The dense style
  // makes runs of equal words, the sparse one spans the whole signed range
  // and ends on the largest word.
  task automatic fill_sorted(int unsigned n);
    longint      cur;
    int unsigned mode;
    int unsigned step_max;
    int          v;
    mode = $urandom_range(0, 2);
    case (mode)
      0: begin
        cur      = int'($urandom);
        step_max = 2;
      end
      1: begin
        cur      = VAL_MIN;
        step_max = (n <= 64) ? 32'h0800_0000 : 32'h0040_0000;
      end
      default: begin
        cur      = int'($urandom);
        step_max = 1000;
      end
    endcase
    for (int unsigned i = 0; i < n; i++) begin
      v = clamp_word(cur);
      if (mode == 1 && i == n - 1) v = VAL_MAX;
      send_write(i, v);
      cur += $urandom_range(0, step_max);
    end
  endtask

  // Mostly values that sit in the table or right next to one, so that the
  // searches meet runs of equal words; the rest are extremes and noise.
  function automatic int pick_query_value(int unsigned n);
    int unsigned sel;
    int          base;
    longint      lo;
    longint      hi;
    if (n == 0) return int'($urandom);
    sel  = $urandom_range(0, 99);
    base = sb.table_word[$urandom_range(0, n - 1)];
    lo   = sb.table_word[0];
    hi   = sb.table_word[n - 1];
    if (sel < 40) return base;
    if (sel < 55) return clamp_word(longint'(base) + 1);
    if (sel < 65) return clamp_word(longint'(base) - 1);
    if (sel < 72) return VAL_MIN;
    if (sel < 79) return VAL_MAX;
    if (sel < 90 && hi >= lo) return int'(lo + longint'($urandom) % (hi - lo + 1));
    return int'($urandom);
  endfunction

  // Most table writes inside the used range keep it ascending; the others
  // land anywhere with any word and may leave the table unsorted.
  task automatic random_write(int unsigned n);
    int unsigned sel;
    int unsigned idx;
    longint      lo;
    longint      hi;
    int          v;
    sel = $urandom_range(0, 99);
    if (sel < 60 && n > 0) begin
      idx = $urandom_range(0, n - 1);
      lo  = (idx > 0) ? sb.table_word[idx - 1] : VAL_MIN;
      hi  = (idx + 1 < n) ? sb.table_word[idx + 1] : VAL_MAX;
      v   = (hi >= lo) ? int'(lo + longint'($urandom) % (hi - lo + 1)) : int'($urandom);
    end else if (sel < 90) begin
      idx = $urandom_range(0, DEPTH - 1);
      v   = int'($urandom);
    end else begin
      idx = $urandom_range(0, 1) ? DEPTH - 1 : 0;
      v   = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
    end
    send_write(idx, v);
  endtask

  // One setting of entry_count followed by a mix of queries and writes.
  // Every position a search can probe is written before the first query.
  // With hold set, the long output hold-off starts once the count is in.
  task automatic run_phase(int unsigned count, int unsigned items, bit hold = 1'b0);
    int unsigned n;
    set_count(count);
    if (hold) hold_request = 1'b1;
    n = (count > DEPTH) ? DEPTH : count;
    if (n <= 64 || !sb.prefix_written(n)) fill_sorted(n);
    for (int unsigned k = 0; k < items; k++) begin
      if ($urandom_range(0, 3) == 0) random_write(n);
      else send_query(pick_query_value(n));
    end
  endtask

  // Hand-picked cases: an empty table, the smallest and largest words, runs
  // of equal words, a value between entries, a write outside the used range
  // and a table that is no longer sorted.
  task automatic directed_checks();
    send_query(0);
    send_query(VAL_MAX);
    set_count(1);
    send_write(0, VAL_MIN);
    send_query(VAL_MIN);
    send_query(VAL_MAX);
    set_count(4);
    apb_write(ADDR_UNMAPPED, 32'hffff_ffff);
    send_write(1, 5);
    send_write(2, 5);
    send_write(3, VAL_MAX);
    send_query(5);
    send_query(4);
    send_query(6);
    send_query(VAL_MAX);
    send_query(VAL_MIN);
    send_write(DEPTH - 1, -1);
    send_query(-1);
    send_write(1, 100);
    send_query(5);
    send_query(100);
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_checks();

    run_phase(2, 20);
    run_phase(3, 20);
    for (int unsigned k = 0; k < 12; k++) begin
      // One phase runs against the long output hold-off.
      run_phase($urandom_range(1, 32), 30, k == 4);
    end
    run_phase(0, 15);
    // A larger table takes deeper searches.
    run_phase(256, 40);
    run_phase(1, 15);

    drain();
    if (sb.expected_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_q.size());
      sb.err_count += sb.expected_q.size();
    end

    $display("Run covered %0d table writes and %0d queries (%0d found), %0d results checked.",
             sb.n_writes, sb.n_queries, sb.n_hits, sb.n_checked);
    $display("Used %0d entry_count settings from zero to 256 entries, one %0d-cycle hold-off.",
             n_settings, HOLD_CYCLES);
    if (sb.err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
